// ----- src/apd_pkg.sv -----
// Shared types and constants for the averaged PD steering block.
// Used by the controller, the datapath and the top level; no dependencies.

package apd_pkg;

    localparam int ERR_W      = 16;  // track error, Q2.13
    localparam int KNOB_W     = 16;  // gain knob, Q1.14
    localparam int STEER_W    = 16;  // steering drive, Q1.14
    localparam int GAIN_W     = 18;  // gains, Q1.16
    localparam int SLIM_W     = 15;  // steer_limit
    localparam int STEP_W     = 16;  // step_limit
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 18;

    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

    localparam cfg_addr_t REG_GAIN_KD   = 3'd0;
    localparam cfg_addr_t REG_STEER_LIM = 3'd1;
    localparam cfg_addr_t REG_STEP_LIM  = 3'd2;
    localparam cfg_addr_t REG_GAIN_LO   = 3'd3;
    localparam cfg_addr_t REG_GAIN_HI   = 3'd4;

    localparam logic signed [GAIN_W-1:0] KD_RESET      = 18'sd655;
    localparam logic        [SLIM_W-1:0] STEER_LIM_RST = 15'd12288;
    localparam logic        [STEP_W-1:0] STEP_LIM_RST  = 16'd8192;
    localparam logic signed [GAIN_W-1:0] GAIN_LO_RESET = -18'sd1311;
    localparam logic signed [GAIN_W-1:0] GAIN_HI_RESET = -18'sd3932;
    localparam logic signed [GAIN_W-1:0] KP_RESET      = -18'sd3277;

    // datapath operation issued by the controller each cycle
    typedef logic [3:0] dp_op_t;

    localparam dp_op_t OP_NONE  = 4'd0;
    localparam dp_op_t OP_LOAD  = 4'd1;  // capture item, read oldest window entry
    localparam dp_op_t OP_WIN   = 4'd2;  // update window, sum and fill count
    localparam dp_op_t OP_DIVI  = 4'd3;  // load divider
    localparam dp_op_t OP_DIVS  = 4'd4;  // one quotient bit
    localparam dp_op_t OP_AVG   = 4'd5;  // signed average and its change
    localparam dp_op_t OP_KPMUL = 4'd6;  // knob interpolation product
    localparam dp_op_t OP_KPSET = 4'd7;  // round, offset, saturate kp
    localparam dp_op_t OP_MUL   = 4'd8;  // kp*avg and kd*derr
    localparam dp_op_t OP_DRV   = 4'd9;  // sum, round, clamp
    localparam dp_op_t OP_SLEW  = 4'd10; // slew limit, load output register

    typedef struct packed {
        logic func;      // item asks for kp recomputation
        logic out_busy;  // output register holds an item not yet taken
    } dp_stat_t;

endpackage

// ----- src/averaged_pd_steer_with_slew_limit_core.sv -----
// Averaged PD steering core, top level: controller plus datapath.
// Depends on apd_pkg, apd_ctrl and apd_datapath.
//
// Each input item pushes one error sample into a window of the last WINDOW_DEPTH
// samples, averages the filled entries (truncated toward zero), optionally
// re-derives kp from the knob, forms kp*avg + kd*d(avg), clamps it to
// +-steer_limit and slew-limits it against the previous output. One result
// item per input item. An item passes through the window update, the
// bit-serial divider for the average, the kp step when func is set, the
// multipliers, the clamp and the slew limit before it reaches the output
// register; the divider sets most of that time. The next item is taken only
// after the result has been loaded into the output register.
// Items are processed one at a time; a finished result waits in the output
// register while the next item is taken, and a result that is still waiting
// when the next one is ready holds the block. Config writes are taken in any
// cycle and should be made while idle.

module averaged_pd_steer_with_slew_limit_core #(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [31:0]                    s_axis_tdata,  // [15:0] error_sample, [31:16] knob
    input  logic                           s_axis_tuser,  // [0] func
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [apd_pkg::STEER_W-1:0]    m_axis_tdata,  // [15:0] steer
    input  logic                           cfg_wr_en,
    input  apd_pkg::cfg_addr_t             cfg_addr,
    input  logic [apd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    apd_pkg::dp_op_t   op;
    apd_pkg::dp_stat_t stat;

    apd_ctrl #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .op            (op)
    );

    apd_datapath #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .op            (op),
        .stat          (stat),
        .in_func       (s_axis_tuser),
        .in_error      (s_axis_tdata[15:0]),
        .in_knob       (s_axis_tdata[31:16]),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ----- src/apd_ctrl.sv -----
// Controller for the averaged PD steering block: sequences one item at a time.
// Depends on apd_pkg.

module apd_ctrl #(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  apd_pkg::dp_stat_t stat,
    output apd_pkg::dp_op_t   op
);

    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = apd_pkg::ERR_W + CNT_W;
    localparam int ITR_W = $clog2(SUM_W);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_WIN   = 4'd1;
    localparam logic [3:0] ST_DIVI  = 4'd2;
    localparam logic [3:0] ST_DIV   = 4'd3;
    localparam logic [3:0] ST_AVG   = 4'd4;
    localparam logic [3:0] ST_KPMUL = 4'd5;
    localparam logic [3:0] ST_KPSET = 4'd6;
    localparam logic [3:0] ST_MUL   = 4'd7;
    localparam logic [3:0] ST_DRV   = 4'd8;
    localparam logic [3:0] ST_SLEW  = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [ITR_W-1:0] itr_reg, itr_next;

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        itr_next   = itr_reg;
        op         = apd_pkg::OP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    op         = apd_pkg::OP_LOAD;
                    state_next = ST_WIN;
                end
            end
            ST_WIN: begin
                op         = apd_pkg::OP_WIN;
                state_next = ST_DIVI;
            end
            ST_DIVI: begin
                op         = apd_pkg::OP_DIVI;
                itr_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                op = apd_pkg::OP_DIVS;
                if (itr_reg == ITR_W'(SUM_W - 1)) begin
                    state_next = ST_AVG;
                end else begin
                    itr_next = itr_reg + 1'b1;
                end
            end
            ST_AVG: begin
                op         = apd_pkg::OP_AVG;
                state_next = stat.func ? ST_KPMUL : ST_MUL;
            end
            ST_KPMUL: begin
                op         = apd_pkg::OP_KPMUL;
                state_next = ST_KPSET;
            end
            ST_KPSET: begin
                op         = apd_pkg::OP_KPSET;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                op         = apd_pkg::OP_MUL;
                state_next = ST_DRV;
            end
            ST_DRV: begin
                op         = apd_pkg::OP_DRV;
                state_next = ST_SLEW;
            end
            ST_SLEW: begin
                // hold until the output register is free
                if (!stat.out_busy) begin
                    op         = apd_pkg::OP_SLEW;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            itr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            itr_reg   <= itr_next;
        end
    end

endmodule

// ----- src/apd_datapath.sv -----
// Datapath for the averaged PD steering block: error window, divider,
// multipliers, clamp and slew limit, configuration and output registers.
// Depends on apd_pkg; driven by apd_ctrl.

module apd_datapath #(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  apd_pkg::dp_op_t                op,
    output apd_pkg::dp_stat_t              stat,
    input  logic                           in_func,
    input  logic [apd_pkg::ERR_W-1:0]      in_error,
    input  logic [apd_pkg::KNOB_W-1:0]     in_knob,
    input  logic                           cfg_wr_en,
    input  apd_pkg::cfg_addr_t             cfg_addr,
    input  logic [apd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [apd_pkg::STEER_W-1:0]    m_axis_tdata
);

    localparam int ERR_W  = apd_pkg::ERR_W;
    localparam int GAIN_W = apd_pkg::GAIN_W;
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SUM_W  = ERR_W + CNT_W;

    // configuration
    logic signed [GAIN_W-1:0]          kd_reg, klo_reg, khi_reg;
    logic [apd_pkg::SLIM_W-1:0]        slim_reg;
    logic [apd_pkg::STEP_W-1:0]        step_reg;

    // item and window state
    logic                              func_reg;
    logic signed [ERR_W-1:0]           err_reg, old_reg;
    logic signed [apd_pkg::KNOB_W-1:0] knob_reg;
    logic [ERR_W-1:0]                  win_mem [WINDOW_DEPTH];
    logic [SLOT_W-1:0]                 slot_reg;
    logic [CNT_W-1:0]                  fill_reg;
    logic signed [SUM_W-1:0]           sum_reg, sum_next;
    logic                              win_full;

    // divider
    logic [CNT_W-1:0]                  rem_reg, rem_next;
    logic [SUM_W-1:0]                  quo_reg;
    logic                              neg_reg;
    logic [CNT_W:0]                    trial, trial_diff;
    logic                              trial_ge;

    // arithmetic
    logic signed [ERR_W-1:0]           avg_reg, prev_avg_reg;
    logic signed [16:0]                q_mag, avg_full;
    logic signed [17:0]                derr_reg;
    logic signed [16:0]                knob_off;
    logic signed [18:0]                gain_span;
    logic signed [35:0]                kprod_reg, kprod_next, kprod_rnd;
    logic signed [20:0]                kp_shift;
    logic signed [21:0]                kp_wide;
    logic signed [GAIN_W-1:0]          kp_reg;
    logic signed [33:0]                pprod_reg, pprod_next;
    logic signed [35:0]                dprod_reg, dprod_next;
    logic signed [36:0]                dsum;
    logic signed [21:0]                dshift, lim_pos, lim_neg, dclamp;
    logic signed [ERR_W-1:0]           drive_reg;
    logic signed [17:0]                delta, stp_pos, stp_neg, steer_wide;
    logic signed [apd_pkg::STEER_W-1:0] prev_steer_reg;
    logic [apd_pkg::STEER_W-1:0]       out_data_reg;
    logic                              out_valid_reg;

    assign stat.func     = func_reg;
    assign stat.out_busy = out_valid_reg && !m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // window bookkeeping
    assign win_full = (fill_reg == CNT_W'(WINDOW_DEPTH));
    assign sum_next = sum_reg
                    - (win_full ? SUM_W'(old_reg) : SUM_W'(0))
                    + SUM_W'(err_reg);

    // restoring divide on the magnitude, one bit an item cycle
    assign trial      = {rem_reg, quo_reg[SUM_W-1]};
    assign trial_diff = trial - {1'b0, fill_reg};
    assign trial_ge   = (trial >= {1'b0, fill_reg});
    assign rem_next   = trial_ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];

    // quotient magnitude never exceeds 32768
    assign q_mag    = $signed({1'b0, quo_reg[ERR_W-1:0]});
    assign avg_full = neg_reg ? -q_mag : q_mag;

    // kp = lo + round((knob + 1.0) / 2 * (hi - lo))
    assign knob_off   = 17'(knob_reg) + 17'sd16384;
    assign gain_span  = 19'(khi_reg) - 19'(klo_reg);
    assign kprod_next = knob_off * gain_span;
    assign kprod_rnd  = kprod_reg + 36'sd16384;
    assign kp_shift   = kprod_rnd[35:15];
    assign kp_wide    = 22'(klo_reg) + 22'(kp_shift);

    assign pprod_next = kp_reg * avg_reg;
    assign dprod_next = kd_reg * derr_reg;

    // drive: round Q4.29 to Q1.14, then clamp
    assign dsum    = 37'(pprod_reg) + 37'(dprod_reg) + 37'sd16384;
    assign dshift  = dsum[36:15];
    assign lim_pos = $signed({7'd0, slim_reg});
    assign lim_neg = -lim_pos;
    always_comb begin
        dclamp = dshift;
        if (dshift > lim_pos) begin
            dclamp = lim_pos;
        end
        if (dshift < lim_neg) begin
            dclamp = lim_neg;
        end
    end

    // slew limit about the previous output
    assign delta   = 18'(drive_reg) - 18'(prev_steer_reg);
    assign stp_pos = $signed({2'd0, step_reg});
    assign stp_neg = -stp_pos;
    always_comb begin
        if (delta > stp_pos) begin
            steer_wide = 18'(prev_steer_reg) + stp_pos;
        end else if (delta < stp_neg) begin
            steer_wide = 18'(prev_steer_reg) + stp_neg;
        end else begin
            steer_wide = 18'(drive_reg);
        end
    end

    // window store: one write, one registered read
    always_ff @(posedge aclk) begin
        if (op == apd_pkg::OP_WIN) begin
            win_mem[slot_reg] <= err_reg;
        end
        if (op == apd_pkg::OP_LOAD) begin
            old_reg <= win_mem[slot_reg];
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kd_reg   <= apd_pkg::KD_RESET;
            slim_reg <= apd_pkg::STEER_LIM_RST;
            step_reg <= apd_pkg::STEP_LIM_RST;
            klo_reg  <= apd_pkg::GAIN_LO_RESET;
            khi_reg  <= apd_pkg::GAIN_HI_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                apd_pkg::REG_GAIN_KD:   kd_reg   <= cfg_wdata;
                apd_pkg::REG_STEER_LIM: slim_reg <= cfg_wdata[apd_pkg::SLIM_W-1:0];
                apd_pkg::REG_STEP_LIM:  step_reg <= cfg_wdata[apd_pkg::STEP_W-1:0];
                apd_pkg::REG_GAIN_LO:   klo_reg  <= cfg_wdata;
                apd_pkg::REG_GAIN_HI:   khi_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // controller-held state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg       <= '0;
            fill_reg       <= '0;
            sum_reg        <= '0;
            prev_avg_reg   <= '0;
            prev_steer_reg <= '0;
            kp_reg         <= apd_pkg::KP_RESET;
            out_valid_reg  <= 1'b0;
        end else begin
            if (op == apd_pkg::OP_WIN) begin
                sum_reg  <= sum_next;
                slot_reg <= (slot_reg == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
                if (!win_full) begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (op == apd_pkg::OP_AVG) begin
                prev_avg_reg <= avg_full[ERR_W-1:0];
            end
            if (op == apd_pkg::OP_KPSET) begin
                if (kp_wide > 22'sd131071) begin
                    kp_reg <= 18'sh1FFFF;
                end else if (kp_wide < -22'sd131072) begin
                    kp_reg <= -18'sd131072;
                end else begin
                    kp_reg <= kp_wide[GAIN_W-1:0];
                end
            end
            if (op == apd_pkg::OP_SLEW) begin
                prev_steer_reg <= steer_wide[apd_pkg::STEER_W-1:0];
                out_valid_reg  <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        case (op)
            apd_pkg::OP_LOAD: begin
                func_reg <= in_func;
                err_reg  <= in_error;
                knob_reg <= in_knob;
            end
            apd_pkg::OP_DIVI: begin
                neg_reg <= sum_reg[SUM_W-1];
                quo_reg <= sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
                rem_reg <= '0;
            end
            apd_pkg::OP_DIVS: begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[SUM_W-2:0], trial_ge};
            end
            apd_pkg::OP_AVG: begin
                avg_reg  <= avg_full[ERR_W-1:0];
                derr_reg <= 18'(avg_full) - 18'(prev_avg_reg);
            end
            apd_pkg::OP_KPMUL: begin
                kprod_reg <= kprod_next;
            end
            apd_pkg::OP_MUL: begin
                pprod_reg <= pprod_next;
                dprod_reg <= dprod_next;
            end
            apd_pkg::OP_DRV: begin
                drive_reg <= dclamp[ERR_W-1:0];
            end
            apd_pkg::OP_SLEW: begin
                out_data_reg <= steer_wide[apd_pkg::STEER_W-1:0];
            end
            default: ;
        endcase
    end

endmodule

// ----- src/apd_port_chk.sv -----
// Port-level checks for the averaged PD steering core, bound to the top level.
// Depends on apd_pkg.

module apd_port_chk (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [apd_pkg::STEER_W-1:0] m_axis_tdata
);

    // no result survives a reset
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // block is ready for an item straight after reset
    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_axis_tready)
        else $error("not ready after reset");

    // one item in work at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while busy");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind averaged_pd_steer_with_slew_limit_core apd_port_chk u_port_chk (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
